@@ hdl/rcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types and constants for the range counting sort block.
// ----------------------------------------------------------------------------
package rcs_pkg;

  localparam int POS_W    = 10;
  localparam int LETTER_W = 5;
  localparam int COUNT_W  = 11;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_SORT_UP   = 2'd1,
    OP_SORT_DOWN = 2'd2,
    OP_READ      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ_WAIT,
    ST_COUNT,
    ST_COUNT_TAIL,
    ST_FILL_LOAD,
    ST_FILL_RUN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic take;
    logic do_write;
    logic do_read;
    logic capture_read;
    logic clear_counts;
    logic letter_init;
    logic count_rd;
    logic pos_reload;
    logic fill_load;
    logic fill_write;
    logic letter_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    op_t  op;
    logic err;
    logic pos_at_hi;
    logic n_zero;
    logic letter_last;
    logic out_free;
  } status_t;

endpackage

@@ hdl/rcs_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_ifs
// Request and response channels of the range counting sort block.
// ----------------------------------------------------------------------------
interface rcs_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic [rcs_pkg::POS_W-1:0]    position_from;
  logic [rcs_pkg::POS_W-1:0]    position_to;
  logic [rcs_pkg::LETTER_W-1:0] letter_in;

  modport source (output valid, operation, position_from, position_to, letter_in,
                  input ready);
  modport sink   (input valid, operation, position_from, position_to, letter_in,
                  output ready);
endinterface

interface rcs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rcs_pkg::LETTER_W-1:0] letter_out;
  logic                        is_error;

  modport source (output valid, letter_out, is_error, input ready);
  modport sink   (input valid, letter_out, is_error, output ready);
endinterface

@@ hdl/rcs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rcs_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/rcs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_ctrl
// Sequencer: decode, read, count pass, fill pass and response.
// ----------------------------------------------------------------------------
module rcs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  rcs_pkg::status_t status,
  output rcs_pkg::cmd_t    cmd
);
  import rcs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (status.in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (status.err) begin
          state_next = ST_RESP;
        end else if (status.op inside {OP_SORT_UP, OP_SORT_DOWN}) begin
          state_next = ST_COUNT;
        end else if (status.op == OP_READ) begin
          state_next = ST_READ_WAIT;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_READ_WAIT: state_next = ST_RESP;
      ST_COUNT: begin
        if (status.pos_at_hi) state_next = ST_COUNT_TAIL;
      end
      ST_COUNT_TAIL: state_next = ST_FILL_LOAD;
      ST_FILL_LOAD:  state_next = ST_FILL_RUN;
      ST_FILL_RUN: begin
        if (status.n_zero) begin
          state_next = status.letter_last ? ST_RESP : ST_FILL_LOAD;
        end
      end
      ST_RESP: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: cmd.take = 1'b1;
      ST_DECODE: begin
        if (!status.err) begin
          case (status.op)
            OP_WRITE: cmd.do_write = 1'b1;
            OP_READ:  cmd.do_read  = 1'b1;
            default: begin
              cmd.clear_counts = 1'b1;
              cmd.letter_init  = 1'b1;
            end
          endcase
        end
      end
      ST_READ_WAIT:  cmd.capture_read = 1'b1;
      ST_COUNT:      cmd.count_rd     = 1'b1;
      ST_COUNT_TAIL: cmd.pos_reload   = 1'b1;
      ST_FILL_LOAD:  cmd.fill_load    = 1'b1;
      ST_FILL_RUN: begin
        if (!status.n_zero) begin
          cmd.fill_write = 1'b1;
        end else if (!status.letter_last) begin
          cmd.letter_step = 1'b1;
        end
      end
      ST_RESP: cmd.load_out = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ hdl/rcs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_datapath
// Item registers, letter store, letter counters and response register.
// ----------------------------------------------------------------------------
module rcs_datapath #(
  parameter int STORE_DEPTH   = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic             clk,
  input  logic             rst,
  rcs_req_if.sink          req,
  rcs_rsp_if.source        rsp,
  input  rcs_pkg::cmd_t    cmd,
  output rcs_pkg::status_t status
);
  import rcs_pkg::*;

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int LW  = $clog2(ALPHABET_SIZE);
  localparam int PW  = POS_W + 1;
  localparam int CMW = 17;
  localparam logic [CMW-1:0] DEPTH_C = CMW'(STORE_DEPTH);
  localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHABET_SIZE - 1);

  function automatic logic [LETTER_W-1:0] sat_letter(input logic [LETTER_W-1:0] v);
    return ({1'b0, v} >= (LETTER_W + 1)'(ALPHABET_SIZE)) ? LAST_LETTER : v;
  endfunction

  op_t                 op_q;
  logic [POS_W-1:0]    from_q;
  logic [POS_W-1:0]    to_q;
  logic [LETTER_W-1:0] letter_q;

  logic [PW-1:0]       pos;
  logic [COUNT_W-1:0]  n;
  logic [LETTER_W-1:0] l;
  logic [LETTER_W-1:0] value;
  logic                rd_pend;
  logic [COUNT_W-1:0]  counts [ALPHABET_SIZE];

  logic                out_valid;
  logic [LETTER_W-1:0] out_letter;
  logic                out_err;

  logic                we;
  logic                re;
  logic [AW-1:0]       addr;
  logic [AW+PW-1:0]    addr_wide;
  logic [LETTER_W-1:0] wdata;
  logic [LETTER_W-1:0] rdata;
  logic [LETTER_W-1:0] rdata_sat;
  logic [LW-1:0]       cidx;
  logic [COUNT_W-1:0]  cval;
  logic                desc;
  logic                err;
  logic                take;

  assign take      = cmd.take && req.valid;
  assign desc      = (op_q == OP_SORT_DOWN);
  assign addr_wide = {{AW{1'b0}}, pos};
  assign addr      = addr_wide[AW-1:0];
  assign we        = cmd.do_write || cmd.fill_write;
  assign re        = cmd.do_read || cmd.count_rd;
  assign wdata     = cmd.fill_write ? l : sat_letter(letter_q);
  assign rdata_sat = sat_letter(rdata);
  assign cidx      = rd_pend ? rdata_sat[LW-1:0] : l[LW-1:0];
  assign cval      = counts[cidx];

  always_comb begin
    if (op_q == OP_WRITE || op_q == OP_READ) begin
      err = ({{(CMW-POS_W){1'b0}}, from_q} >= DEPTH_C);
    end else begin
      err = (from_q > to_q) || ({{(CMW-POS_W){1'b0}}, to_q} >= DEPTH_C);
    end
  end

  rcs_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .re    (re),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (take) begin
      op_q     <= op_t'(req.operation);
      from_q   <= req.position_from;
      to_q     <= req.position_to;
      letter_q <= req.letter_in;
      pos      <= {1'b0, req.position_from};
      value    <= '0;
    end else begin
      if (cmd.count_rd || cmd.fill_write) pos <= pos + PW'(1);
      if (cmd.pos_reload) pos <= {1'b0, from_q};
      if (cmd.capture_read) value <= rdata;
    end
    if (cmd.letter_init) l <= (op_q == OP_SORT_DOWN) ? LAST_LETTER : '0;
    if (cmd.letter_step) l <= desc ? l - LETTER_W'(1) : l + LETTER_W'(1);
    if (cmd.fill_load) n <= cval;
    if (cmd.fill_write) n <= n - COUNT_W'(1);
  end

  // counters: cleared at reset and at the start of every sort
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_counts) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        counts[i] <= '0;
      end
    end else if (rd_pend) begin
      counts[cidx] <= cval + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= cmd.count_rd;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_letter <= value;
      out_err    <= err;
    end
  end

  assign req.ready      = cmd.take;
  assign rsp.valid      = out_valid;
  assign rsp.letter_out = out_letter;
  assign rsp.is_error   = out_err;

  assign status.in_valid    = req.valid;
  assign status.op          = op_q;
  assign status.err         = err;
  assign status.pos_at_hi   = (pos == {1'b0, to_q});
  assign status.n_zero      = (n == '0);
  assign status.letter_last = desc ? (l == '0) : (l == LAST_LETTER);
  assign status.out_free    = !out_valid || rsp.ready;

endmodule

@@ hdl/range_counting_sort_letters.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_counting_sort_letters
// Letter store with write, read and ascending/descending range sort.
// ----------------------------------------------------------------------------
// One word in, one word out, one item at a time. A sort of n positions
// runs a count pass that reads one entry a cycle from the letter store,
// then a fill pass that writes one entry a cycle plus a load state and a
// closing step per letter code. The response sits in an output register,
// so the next item is taken while the previous response waits. The store
// holds no reset value; read only what was written.
module range_counting_sort_letters #(
  parameter int STORE_DEPTH   = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic      clk,
  input  logic      rst,
  rcs_req_if.sink   req,
  rcs_rsp_if.source rsp
);
  import rcs_pkg::*;

  cmd_t    cmd;
  status_t status;

  rcs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  rcs_datapath #(
    .STORE_DEPTH   (STORE_DEPTH),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .cmd    (cmd),
    .status (status)
  );

endmodule

@@ dv/rcs_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_result_checker
// Watches both channels of the letter sort block. Every accepted request
// word is run through a local copy of the letter store and counters, and
// each response word is compared, field by field, with the oldest
// prediction. The number of failures and of outstanding predictions are
// handed to the top.
// ----------------------------------------------------------------------------
module rcs_result_checker #(
  parameter int STORE_DEPTH   = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic clk,
  input  logic rst,
  rcs_req_if   req,
  rcs_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);
  import rcs_pkg::*;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                err;
  } letter_result_t;

  logic [LETTER_W-1:0] letter_store  [STORE_DEPTH];
  logic [COUNT_W-1:0]  letter_counts [ALPHABET_SIZE];
  letter_result_t      expected_letters [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    for (int a = 0; a < ALPHABET_SIZE; a++) letter_counts[a] = '0;
  end

  task automatic fill_letter_run(inout int pos, input int code);
    int n;
    n = letter_counts[code];
    while (n > 0 && pos < STORE_DEPTH) begin
      letter_store[pos] = LETTER_W'(code);
      pos++;
      n--;
    end
  endtask

  task automatic apply_letter_op(input op_t op, input int from, input int to,
                                 input int code, output letter_result_t res);
    int c;
    int pos;
    res = '0;
    case (op)
      OP_WRITE, OP_READ: begin
        if (from >= STORE_DEPTH) begin
          res.err = 1'b1;
        end else if (op == OP_WRITE) begin
          if (code >= ALPHABET_SIZE) code = ALPHABET_SIZE - 1;
          letter_store[from] = LETTER_W'(code);
        end else begin
          res.letter = letter_store[from];
        end
      end
      default: begin
        if (from > to || to >= STORE_DEPTH) begin
          res.err = 1'b1;
        end else begin
          for (int a = 0; a < ALPHABET_SIZE; a++) letter_counts[a] = '0;
          for (int i = from; i <= to; i++) begin
            c = letter_store[i];
            if (c >= ALPHABET_SIZE) c = ALPHABET_SIZE - 1;
            letter_counts[c] = letter_counts[c] + 1'b1;
          end
          pos = from;
          if (op == OP_SORT_DOWN) begin
            for (int a = ALPHABET_SIZE - 1; a >= 0; a--) fill_letter_run(pos, a);
          end else begin
            for (int a = 0; a < ALPHABET_SIZE; a++) fill_letter_run(pos, a);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    letter_result_t want;
    letter_result_t pred;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (expected_letters.size() == 0) begin
          $display("%0t: response word with nothing expected (letter %0d, error %0b)",
                   $time, rsp.letter_out, rsp.is_error);
          fail_count++;
        end else begin
          want = expected_letters.pop_front();
          if (rsp.letter_out !== want.letter) begin
            $display("%0t: letter_out mismatch, expected %0d, got %0d",
                     $time, want.letter, rsp.letter_out);
            fail_count++;
          end
          if (rsp.is_error !== want.err) begin
            $display("%0t: is_error mismatch, expected %0b, got %0b",
                     $time, want.err, rsp.is_error);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        apply_letter_op(op_t'(req.operation), int'(req.position_from),
                        int'(req.position_to), int'(req.letter_in), pred);
        expected_letters = {expected_letters, pred};
      end
    end
    pending = expected_letters.size();
  end

endmodule

@@ dv/tb_range_counting_sort_letters.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_counting_sort_letters
// Drives the letter sort block with a short directed sequence (field
// extremes, saturating writes, one-position and inverted sort ranges) and
// then random words: bursts of writes that build contiguous letter runs,
// single writes, reads of written positions, sorts inside written runs
// and inverted sort ranges. Both sides idle at random; rcs_result_checker checks.
// ----------------------------------------------------------------------------
module tb_range_counting_sort_letters;
  import rcs_pkg::*;

  localparam int STORE_DEPTH   = 1024;
  localparam int ALPHABET_SIZE = 26;
  localparam int RANDOM_WORDS  = 260;
  localparam int CYCLE_LIMIT   = 4_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   cycles = 0;

  bit   written [STORE_DEPTH];
  int   send_quiet = 0;
  int   recv_quiet = 0;
  int   n_writes = 0;
  int   n_reads = 0;
  int   n_sorts = 0;
  int   n_inverted = 0;
  int   longest_sort = 0;

  rcs_req_if req ();
  rcs_rsp_if rsp ();

  range_counting_sort_letters #(
    .STORE_DEPTH   (STORE_DEPTH),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  rcs_result_checker #(
    .STORE_DEPTH   (STORE_DEPTH),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int next_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  function automatic int find_written(input int start);
    int idx;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      idx = (start + i) % STORE_DEPTH;
      if (written[idx]) return idx;
    end
    return -1;
  endfunction

  task automatic send_word(input op_t op, input int from, input int to, input int code);
    int gap;
    gap = next_gap(send_quiet);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.operation     <= op;
    req.position_from <= POS_W'(from);
    req.position_to   <= POS_W'(to);
    req.letter_in     <= LETTER_W'(code);
    req.valid         <= 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
    case (op)
      OP_WRITE: begin
        written[from] = 1'b1;
        n_writes++;
      end
      OP_READ: n_reads++;
      default: begin
        if (from > to) begin
          n_inverted++;
        end else begin
          n_sorts++;
          if (to - from + 1 > longest_sort) longest_sort = to - from + 1;
        end
      end
    endcase
  endtask

  // response side: random back-pressure per word
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = next_gap(recv_quiet);
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int made;
    int choice;
    int base;
    int len;
    int p;
    int lo;
    int hi;
    int from;
    int to;
    op_t op;

    req.valid         = 1'b0;
    req.operation     = OP_WRITE;
    req.position_from = '0;
    req.position_to   = '0;
    req.letter_in     = '0;
    rsp.ready         = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed
    send_word(OP_WRITE, 0, 1023, 0);
    send_word(OP_WRITE, 1023, 0, 25);
    send_word(OP_WRITE, 1, 512, 31);
    send_word(OP_WRITE, 2, 0, 26);
    send_word(OP_WRITE, 3, 1023, 7);
    send_word(OP_WRITE, 4, 0, 3);
    send_word(OP_WRITE, 5, 341, 20);
    send_word(OP_WRITE, 6, 682, 3);
    send_word(OP_WRITE, 7, 0, 12);
    send_word(OP_READ, 0, 1023, 31);
    send_word(OP_READ, 1023, 0, 0);
    send_word(OP_READ, 1, 0, 0);
    send_word(OP_SORT_UP, 0, 7, 31);
    send_word(OP_READ, 0, 0, 0);
    send_word(OP_READ, 7, 0, 0);
    send_word(OP_SORT_DOWN, 0, 7, 0);
    send_word(OP_READ, 0, 0, 0);
    send_word(OP_SORT_UP, 5, 5, 0);
    send_word(OP_SORT_UP, 7, 3, 0);
    send_word(OP_SORT_DOWN, 1023, 0, 31);
    send_word(OP_WRITE, 1022, 0, 9);
    send_word(OP_SORT_DOWN, 1022, 1023, 0);
    send_word(OP_READ, 1022, 0, 0);
    send_word(OP_READ, 1023, 1023, 31);

    // hold off until the block has drained
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    made = 0;
    while (made < RANDOM_WORDS) begin
      if (made >= RANDOM_WORDS / 2 && made < RANDOM_WORDS / 2 + 3) begin
        req.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      choice = $urandom_range(0, 99);
      if (choice < 15) begin
        base = $urandom_range(0, STORE_DEPTH - 1);
        len  = $urandom_range(2, 20);
        for (int k = 0; k < len && base + k < STORE_DEPTH; k++) begin
          send_word(OP_WRITE, base + k, $urandom_range(0, 1023), $urandom_range(0, 31));
          made++;
        end
      end else if (choice < 35) begin
        send_word(OP_WRITE, $urandom_range(0, STORE_DEPTH - 1), $urandom_range(0, 1023),
                  $urandom_range(0, 31));
        made++;
      end else if (choice < 57) begin
        p = find_written($urandom_range(0, STORE_DEPTH - 1));
        send_word(OP_READ, p, $urandom_range(0, 1023), $urandom_range(0, 31));
        made++;
      end else if (choice < 88) begin
        p  = find_written($urandom_range(0, STORE_DEPTH - 1));
        lo = p;
        hi = p;
        while (lo > 0 && written[lo-1]) lo--;
        while (hi < STORE_DEPTH - 1 && written[hi+1]) hi++;
        from = $urandom_range(lo, hi);
        to   = $urandom_range(from, hi);
        if (to - from > 48 && $urandom_range(0, 7) != 0) to = from + $urandom_range(0, 48);
        if ($urandom_range(0, 5) == 0) begin
          from = lo;
          to   = hi;
        end
        op = $urandom_range(0, 1) ? OP_SORT_UP : OP_SORT_DOWN;
        send_word(op, from, to, $urandom_range(0, 31));
        made++;
      end else begin
        from = $urandom_range(1, STORE_DEPTH - 1);
        to   = $urandom_range(0, from - 1);
        op   = $urandom_range(0, 1) ? OP_SORT_UP : OP_SORT_DOWN;
        send_word(op, from, to, $urandom_range(0, 31));
        made++;
      end
    end
    req.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("summary: %0d writes, %0d reads, %0d sorts, %0d inverted ranges",
             n_writes, n_reads, n_sorts, n_inverted);
    $display("summary: longest sorted range %0d positions, %0d cycles", longest_sort, cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rcs_pkg.sv
hdl/rcs_ifs.sv
hdl/rcs_ram.sv
hdl/rcs_ctrl.sv
hdl/rcs_datapath.sv
hdl/range_counting_sort_letters.sv
dv/rcs_result_checker.sv
dv/tb_range_counting_sort_letters.sv
